@@ hw/rtl/m68k_pkg.sv @@
// Shared types, opcode classes and decode for the 68000 execute subset.
package m68k_pkg;

   localparam int RegCount    = 16;
   localparam int RegAddrBits = $clog2(RegCount);
   localparam int WordBits    = 32;
   localparam int CcrBits     = 5;

   localparam logic [15:0] NOP_WORD = 16'h4E71;

   // opcode word fields: top nibble, size field, effective address mode and register
   localparam logic [3:0] OPC_MOVE_L = 4'h2;
   localparam logic [3:0] OPC_QUICK  = 4'h5;
   localparam logic [3:0] OPC_MOVEQ  = 4'h7;
   localparam logic [3:0] OPC_CMP    = 4'hB;
   localparam logic [3:0] OPC_ADD    = 4'hD;
   localparam logic [1:0] SZ_BYTE    = 2'd0;
   localparam logic [1:0] SZ_WORD    = 2'd1;
   localparam logic [1:0] SZ_LONG    = 2'd2;
   localparam logic [1:0] SZ_SPECIAL = 2'd3;
   localparam logic [2:0] EA_DREG    = 3'd0;
   localparam logic [2:0] EA_AREG    = 3'd1;
   localparam logic [2:0] EA_AIND    = 3'd2;
   localparam logic [2:0] EA_SPECIAL = 3'd7;
   localparam logic [2:0] EA_IMM_REG = 3'd4;

   // timing per instruction class
   localparam logic [2:0] PC_STEP_SHORT = 3'd2;
   localparam logic [2:0] PC_STEP_IMM   = 3'd6;
   localparam logic [3:0] CYC_SHORT     = 4'd4;
   localparam logic [3:0] CYC_LONG      = 4'd8;

   // condition code bit positions
   localparam int CCR_X = 4;
   localparam int CCR_N = 3;
   localparam int CCR_Z = 2;
   localparam int CCR_V = 1;
   localparam int CCR_C = 0;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_MOVEQ,
      OP_NOP,
      OP_ADD,
      OP_ADDQ_D,
      OP_ADDQ_A,
      OP_MOVEI_D,
      OP_MOVEI_A,
      OP_MOVE_D,
      OP_CMP
   } op_type;

   // classify one opcode word, first match wins
   function automatic op_type decode_op(input logic [15:0] w);
      logic [3:0] top;
      logic [1:0] szf;
      logic [2:0] mode;
      logic [2:0] rlo;
      logic [2:0] dmode;
      logic       bit8;
      op_type     op;
      top   = w[15:12];
      szf   = w[7:6];
      mode  = w[5:3];
      rlo   = w[2:0];
      dmode = w[8:6];
      bit8  = w[8];
      op    = OP_NONE;
      if (top == OPC_MOVEQ) begin
         op = OP_MOVEQ;
      end else if (w == NOP_WORD) begin
         op = OP_NOP;
      end else if (top == OPC_ADD && szf == SZ_LONG && !bit8 && mode == EA_DREG) begin
         op = OP_ADD;
      end else if (top == OPC_QUICK && szf == SZ_LONG && mode == EA_DREG) begin
         op = OP_ADDQ_D;
      end else if (top == OPC_QUICK && szf != SZ_SPECIAL && mode == EA_AREG) begin
         op = OP_ADDQ_A;
      end else if (top == OPC_MOVE_L && mode == EA_SPECIAL && rlo == EA_IMM_REG) begin
         if (dmode == EA_DREG) begin
            op = OP_MOVEI_D;
         end else if (dmode == EA_AREG) begin
            op = OP_MOVEI_A;
         end else begin
            op = OP_NONE;
         end
      end else if (top == OPC_MOVE_L && mode == EA_DREG && dmode == EA_DREG) begin
         op = OP_MOVE_D;
      end else if (top == OPC_CMP && szf == SZ_LONG && !bit8 && mode == EA_DREG) begin
         op = OP_CMP;
      end
      return op;
   endfunction

endpackage

@@ hw/rtl/m68k_fast_subset_execute.sv @@
// 68000 integer execute subset: register file memory, operand read stage, execute stage.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | instruction_word, extension_long
//   rsp     | out       | rsp_valid/rsp_stall  | handled, pc/cycles/ccr after, dest info
//
// One instruction per cycle sustained while the output is not stalled; an accepted
// instruction passes the read stage, then the output register. The read stage reads
// both source operands from the 16-entry register file memory (two registered read
// ports); the execute stage executes, writes back and loads the output register. A
// write that lands on the same edge as the next read is forwarded. Reset clears the
// per-entry valid bits, so unwritten registers read as zero; no clearing pass. A
// stalled result holds the execute stage, which in turn stalls the input.
module m68k_fast_subset_execute
   import m68k_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [15:0]           req_instruction_word,
   input  logic [WordBits-1:0]   req_extension_long,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_handled,
   output logic [WordBits-1:0]   rsp_pc_after,
   output logic [WordBits-1:0]   rsp_cycles_after,
   output logic [CcrBits-1:0]    rsp_ccr_after,
   output logic                  rsp_dest_written,
   output logic [RegAddrBits-1:0] rsp_dest_index,
   output logic [WordBits-1:0]   rsp_dest_value
);

   // register file: D0-D7 at 0-7, A0-A7 at 8-15
   logic [WordBits-1:0]    reg_mem [RegCount];
   logic [RegCount-1:0]    reg_ok_ff;

   // read stage
   logic                   s1_valid_ff;
   op_type                 s1_op_ff;
   logic [15:0]            s1_word_ff;
   logic [WordBits-1:0]    s1_ext_ff;
   logic [RegAddrBits-1:0] a_addr_ff;
   logic [RegAddrBits-1:0] b_addr_ff;
   logic [WordBits-1:0]    rd_a_ff;
   logic [WordBits-1:0]    rd_b_ff;
   logic                   rd_a_ok_ff;
   logic                   rd_b_ok_ff;
   logic                   fwd_valid_ff;
   logic [RegAddrBits-1:0] fwd_addr_ff;
   logic [WordBits-1:0]    fwd_data_ff;

   // architectural scalars
   logic [WordBits-1:0]    pc_ff;
   logic [WordBits-1:0]    cycles_ff;
   logic [CcrBits-1:0]     ccr_ff;

   // output register
   logic                   rsp_valid_ff;
   logic                   rsp_handled_ff;
   logic [WordBits-1:0]    rsp_pc_ff;
   logic [WordBits-1:0]    rsp_cycles_ff;
   logic [CcrBits-1:0]     rsp_ccr_ff;
   logic                   rsp_written_ff;
   logic [RegAddrBits-1:0] rsp_index_ff;
   logic [WordBits-1:0]    rsp_value_ff;

   logic                   accept;
   logic                   advance;
   logic [RegAddrBits-1:0] a_addr_in;
   logic [RegAddrBits-1:0] b_addr_in;

   // execute results
   logic [WordBits-1:0]    opnd_a;
   logic [WordBits-1:0]    opnd_b;
   logic [WordBits-1:0]    src;
   logic [WordBits-1:0]    dst;
   logic [WordBits-1:0]    sum;
   logic                   sub;
   logic                   carry;
   logic                   ovf;
   logic [WordBits-1:0]    quick;
   logic [2:0]             rhi;
   logic [2:0]             rlo;
   logic                   res_handled;
   logic                   res_written;
   logic [RegAddrBits-1:0] res_index;
   logic [WordBits-1:0]    res_value;
   logic [CcrBits-1:0]     res_ccr;
   logic [2:0]             pc_step;
   logic [3:0]             cyc_step;
   logic                   wr_en;

   // handshake
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // operand addresses: port a is Dm or An (quick to An), port b is Dn
   assign a_addr_in = {(req_instruction_word[15:12] == OPC_QUICK)
                       && (req_instruction_word[5:3] == EA_AREG),
                       req_instruction_word[2:0]};
   assign b_addr_in = {1'b0, req_instruction_word[11:9]};

   // register file memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         reg_mem[res_index] <= res_value;
      end
      if (accept) begin
         rd_a_ff <= reg_mem[a_addr_in];
         rd_b_ff <= reg_mem[b_addr_in];
      end
   end

   // read stage control and captured operands state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         reg_ok_ff    <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff  <= 1'b1;
            fwd_valid_ff <= wr_en;
         end else if (advance) begin
            s1_valid_ff  <= 1'b0;
         end
         if (wr_en) begin
            reg_ok_ff[res_index] <= 1'b1;
         end
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= decode_op(req_instruction_word);
         s1_word_ff  <= req_instruction_word;
         s1_ext_ff   <= req_extension_long;
         a_addr_ff   <= a_addr_in;
         b_addr_ff   <= b_addr_in;
         rd_a_ok_ff  <= reg_ok_ff[a_addr_in];
         rd_b_ok_ff  <= reg_ok_ff[b_addr_in];
         fwd_addr_ff <= res_index;
         fwd_data_ff <= res_value;
      end
   end

   // forward a write that landed with the read, else mask unwritten entries
   always_comb begin
      if (fwd_valid_ff && fwd_addr_ff == a_addr_ff) begin
         opnd_a = fwd_data_ff;
      end else begin
         opnd_a = rd_a_ok_ff ? rd_a_ff : '0;
      end
      if (fwd_valid_ff && fwd_addr_ff == b_addr_ff) begin
         opnd_b = fwd_data_ff;
      end else begin
         opnd_b = rd_b_ok_ff ? rd_b_ff : '0;
      end
   end

   // execute: adder with flags, result select
   always_comb begin
      rhi   = s1_word_ff[11:9];
      rlo   = s1_word_ff[2:0];
      quick = (rhi == 3'd0) ? WordBits'(8) : WordBits'(rhi);
      sub   = 1'b0;
      src   = opnd_a;
      dst   = opnd_b;
      case (s1_op_ff)
         OP_ADDQ_D, OP_ADDQ_A: begin
            sub = s1_word_ff[8];
            src = quick;
            dst = opnd_a;
         end
         OP_CMP: begin
            sub = 1'b1;
         end
         default: begin
            sub = 1'b0;
         end
      endcase
      sum = sub ? (dst - src) : (dst + src);
      if (sub) begin
         carry = ((~dst[31]) & src[31]) | (((~dst[31]) | src[31]) & sum[31]);
         ovf   = (src[31] ^ dst[31]) & (dst[31] ^ sum[31]);
      end else begin
         carry = (src[31] & dst[31]) | ((src[31] | dst[31]) & ~sum[31]);
         ovf   = (src[31] ^ sum[31]) & (dst[31] ^ sum[31]);
      end

      res_handled = 1'b1;
      res_written = 1'b0;
      res_index   = '0;
      res_value   = '0;
      res_ccr     = ccr_ff;
      pc_step     = PC_STEP_SHORT;
      cyc_step    = CYC_LONG;
      case (s1_op_ff)
         OP_MOVEQ: begin
            res_value   = {{(WordBits-8){s1_word_ff[7]}}, s1_word_ff[7:0]};
            res_written = 1'b1;
            res_index   = {1'b0, rhi};
            cyc_step    = CYC_SHORT;
         end
         OP_NOP: begin
            cyc_step = CYC_SHORT;
         end
         OP_ADD: begin
            res_value   = sum;
            res_written = 1'b1;
            res_index   = {1'b0, rhi};
         end
         OP_ADDQ_D: begin
            res_value   = sum;
            res_written = 1'b1;
            res_index   = {1'b0, rlo};
         end
         OP_ADDQ_A: begin
            res_value   = sum;
            res_written = 1'b1;
            res_index   = {1'b1, rlo};
         end
         OP_MOVEI_D: begin
            res_value   = s1_ext_ff;
            res_written = 1'b1;
            res_index   = {1'b0, rhi};
            pc_step     = PC_STEP_IMM;
         end
         OP_MOVEI_A: begin
            res_value   = s1_ext_ff;
            res_written = 1'b1;
            res_index   = {1'b1, rhi};
            pc_step     = PC_STEP_IMM;
         end
         OP_MOVE_D: begin
            res_value   = opnd_a;
            res_written = 1'b1;
            res_index   = {1'b0, rhi};
         end
         OP_CMP: begin
            res_value = sum;
            res_index = {1'b0, rhi};
         end
         default: begin
            res_handled = 1'b0;
         end
      endcase

      // condition codes per class
      case (s1_op_ff)
         OP_MOVEQ, OP_MOVEI_D, OP_MOVE_D: begin
            res_ccr = {ccr_ff[CCR_X], res_value[31], res_value == '0, 1'b0, 1'b0};
         end
         OP_ADD, OP_ADDQ_D: begin
            res_ccr = {carry, sum[31], sum == '0, ovf, carry};
         end
         OP_CMP: begin
            res_ccr = {ccr_ff[CCR_X], sum[31], sum == '0, ovf, carry};
         end
         default: begin
            res_ccr = ccr_ff;
         end
      endcase
   end

   assign wr_en = advance && res_written;

   // retire: update scalars
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         cycles_ff <= '0;
         ccr_ff    <= '0;
      end else if (advance && res_handled) begin
         pc_ff     <= pc_ff + WordBits'(pc_step);
         cycles_ff <= cycles_ff + WordBits'(cyc_step);
         ccr_ff    <= res_ccr;
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_handled_ff <= res_handled;
         rsp_pc_ff      <= res_handled ? pc_ff + WordBits'(pc_step) : pc_ff;
         rsp_cycles_ff  <= res_handled ? cycles_ff + WordBits'(cyc_step) : cycles_ff;
         rsp_ccr_ff     <= res_handled ? res_ccr : ccr_ff;
         rsp_written_ff <= res_written;
         rsp_index_ff   <= res_index;
         rsp_value_ff   <= res_value;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_handled      = rsp_handled_ff;
   assign rsp_pc_after     = rsp_pc_ff;
   assign rsp_cycles_after = rsp_cycles_ff;
   assign rsp_ccr_after    = rsp_ccr_ff;
   assign rsp_dest_written = rsp_written_ff;
   assign rsp_dest_index   = rsp_index_ff;
   assign rsp_dest_value   = rsp_value_ff;

   // an unhandled word reports no destination
   a_unhandled_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_handled |->
         !rsp_dest_written && rsp_dest_index == '0 && rsp_dest_value == '0)
      else $error("unhandled word reports a destination");

   // input stalls only while the read stage holds a transaction
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty read stage");

   // an unhandled word leaves the scalar state alone
   a_unhandled_state: assert property (@(posedge clock) disable iff (reset)
      advance && !res_handled |=> $stable(pc_ff) && $stable(cycles_ff) && $stable(ccr_ff))
      else $error("unhandled word changed state");

   // a written register becomes readable
   a_write_marks: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> reg_ok_ff[$past(res_index)])
      else $error("written register not marked valid");

endmodule
